// ----- hw/rtl/jbat_pkg.sv -----
// Shared types, codes and defaults of the journal block absorb tracker.
`default_nettype none
package jbat_pkg;

    localparam int LOG_ENTRIES_DEF   = 32;
    localparam int MAX_OP_BLOCKS_DEF = 10;

    localparam int BLK_W      = 32;
    localparam int AREA_W     = 12;
    localparam int OPEN_W     = 6;
    localparam int OPEN_LIMIT = 63;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [AREA_W-1:0] AREA_RESET = 12'd33;

    // Opcodes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_START     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_AREA_SIZE = 1'd1;

    // Result status codes
    localparam logic [3:0] STAT_GRANTED     = 4'd0;
    localparam logic [3:0] STAT_WAIT        = 4'd1;
    localparam logic [3:0] STAT_ENDED       = 4'd2;
    localparam logic [3:0] STAT_COMMIT_ENTRY = 4'd3;
    localparam logic [3:0] STAT_COMMIT_EMPTY = 4'd4;
    localparam logic [3:0] STAT_ABSORBED    = 4'd5;
    localparam logic [3:0] STAT_APPENDED    = 4'd6;
    localparam logic [3:0] STAT_TOO_BIG     = 4'd7;
    localparam logic [3:0] STAT_OUTSIDE     = 4'd8;
    localparam logic [3:0] STAT_UNMATCHED   = 4'd9;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [BLK_W-1:0] block_number;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       status;
        logic [BLK_W-1:0] home_block;
        logic [BLK_W-1:0] log_slot_block;
        logic             last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_COMMIT_RD,
        S_COMMIT_OUT,
        S_PUT
    } t_state;

endpackage
`default_nettype wire

// ----- hw/rtl/journal_block_absorb_tracker.sv -----
// Top level of the journal block absorb tracker: sequencer, block list and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries begin, end and
//   block-write items. Output channel (o_out_valid / i_out_ready / o_out_item)
//   returns one result per begin, write or end, but a final end that commits a
//   non-empty list returns one per listed block (last set on the final one).
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) sets the log header
//   block and the log area size; write it only while the block is idle.
// Sequencing:
//   One item at a time. A begin or end passes through S_EXEC and S_PUT, which
//   loads the output register. A block write scans the list through the single
//   memory read port and the shared 32-bit comparator, visiting S_SCAN_RD and
//   then S_SCAN_CMP for each entry searched. A commit reads each entry in
//   S_COMMIT_RD and emits it in S_COMMIT_OUT, forming each slot address in the shared adder.
//   o_in_ready rises again as the last result enters the output register, so the
//   next item can enter while that result waits.
// Reset clears the open-operation count, the entry count and the output valid
// flag; list contents stay undefined and are never read before written.
// A stalled receiver holds the result register; the sequencer waits for it.
`default_nettype none
module journal_block_absorb_tracker #(
    parameter int LOG_ENTRIES   = jbat_pkg::LOG_ENTRIES_DEF,
    parameter int MAX_OP_BLOCKS = jbat_pkg::MAX_OP_BLOCKS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire jbat_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output jbat_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [jbat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [jbat_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(LOG_ENTRIES);
    localparam int CNT_W  = $clog2(LOG_ENTRIES + 1);
    localparam int NEED_W = $clog2(LOG_ENTRIES
                                   + (jbat_pkg::OPEN_LIMIT + 1) * MAX_OP_BLOCKS + 1);
    localparam int AREA_CMP_W = jbat_pkg::AREA_W + 1;
    localparam int OPEN_W = jbat_pkg::OPEN_W;
    localparam int BLK_W  = jbat_pkg::BLK_W;

    // Configuration registers
    logic [BLK_W-1:0]            r_log_start;
    logic [jbat_pkg::AREA_W-1:0] r_log_area_size;

    // Control state
    jbat_pkg::t_state r_state, n_state;
    logic [OPEN_W-1:0] r_open, n_open;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    logic [1:0]          r_op, n_op;
    logic [BLK_W-1:0]    r_blk, n_blk;
    logic [3:0]          r_pend, n_pend;
    jbat_pkg::t_out_item r_out_item, n_out_item;
    logic [BLK_W-1:0]    r_rd_data;

    // Block list memory
    logic [BLK_W-1:0] r_mem [LOG_ENTRIES];
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_addr;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_idx_last;
    logic             w_blk_hit;
    logic             w_begin_ok;
    logic             w_too_big;
    logic [NEED_W-1:0] w_need;
    logic [BLK_W-1:0] w_slot;

    assign o_in_ready  = (r_state == jbat_pkg::S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Room check for one more operation
    assign w_need = NEED_W'(r_count)
                  + NEED_W'({1'b0, r_open} + (OPEN_W + 1)'(1)) * NEED_W'(MAX_OP_BLOCKS);
    assign w_begin_ok = (w_need <= NEED_W'(LOG_ENTRIES))
                     && (r_open < OPEN_W'(jbat_pkg::OPEN_LIMIT));
    assign w_too_big = (r_count >= CNT_W'(LOG_ENTRIES))
                    || ((AREA_CMP_W'(r_count) + AREA_CMP_W'(1))
                        >= AREA_CMP_W'(r_log_area_size));

    // Shared compare and add unit
    assign w_blk_hit  = (r_rd_data == r_blk);
    assign w_idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_slot     = r_log_start + BLK_W'(r_idx) + BLK_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jbat_pkg::S_IDLE: begin
                if (w_in_acc) n_state = jbat_pkg::S_EXEC;
            end
            jbat_pkg::S_EXEC: begin
                case (r_op)
                    jbat_pkg::OP_BEGIN: n_state = jbat_pkg::S_PUT;
                    jbat_pkg::OP_WRITE: begin
                        if (w_too_big || r_open == '0 || r_count == '0) begin
                            n_state = jbat_pkg::S_PUT;
                        end else begin
                            n_state = jbat_pkg::S_SCAN_RD;
                        end
                    end
                    jbat_pkg::OP_END: begin
                        if (r_open == OPEN_W'(1) && r_count != '0) begin
                            n_state = jbat_pkg::S_COMMIT_RD;
                        end else begin
                            n_state = jbat_pkg::S_PUT;
                        end
                    end
                    default: n_state = jbat_pkg::S_IDLE;
                endcase
            end
            jbat_pkg::S_SCAN_RD: n_state = jbat_pkg::S_SCAN_CMP;
            jbat_pkg::S_SCAN_CMP: begin
                if (w_blk_hit || w_idx_last) begin
                    n_state = jbat_pkg::S_PUT;
                end else begin
                    n_state = jbat_pkg::S_SCAN_RD;
                end
            end
            jbat_pkg::S_COMMIT_RD: n_state = jbat_pkg::S_COMMIT_OUT;
            jbat_pkg::S_COMMIT_OUT: begin
                if (w_out_free) begin
                    n_state = w_idx_last ? jbat_pkg::S_IDLE : jbat_pkg::S_COMMIT_RD;
                end
            end
            jbat_pkg::S_PUT: begin
                if (w_out_free) n_state = jbat_pkg::S_IDLE;
            end
            default: n_state = jbat_pkg::S_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        n_open      = r_open;
        n_count     = r_count;
        n_idx       = r_idx;
        n_op        = r_op;
        n_blk       = r_blk;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        w_mem_we    = 1'b0;
        w_mem_addr  = r_count[IDX_W-1:0];
        case (r_state)
            jbat_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_op  = i_in_item.opcode;
                    n_blk = i_in_item.block_number;
                end
            end
            jbat_pkg::S_EXEC: begin
                n_idx = '0;
                case (r_op)
                    jbat_pkg::OP_BEGIN: begin
                        if (w_begin_ok) begin
                            n_open = r_open + OPEN_W'(1);
                            n_pend = jbat_pkg::STAT_GRANTED;
                        end else begin
                            n_pend = jbat_pkg::STAT_WAIT;
                        end
                    end
                    jbat_pkg::OP_WRITE: begin
                        if (w_too_big) begin
                            n_pend = jbat_pkg::STAT_TOO_BIG;
                        end else if (r_open == '0) begin
                            n_pend = jbat_pkg::STAT_OUTSIDE;
                        end else if (r_count == '0) begin
                            // Empty list: append at once
                            w_mem_we = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_pend   = jbat_pkg::STAT_APPENDED;
                        end
                    end
                    jbat_pkg::OP_END: begin
                        if (r_open == '0) begin
                            n_pend = jbat_pkg::STAT_UNMATCHED;
                        end else begin
                            n_open = r_open - OPEN_W'(1);
                            if (r_open != OPEN_W'(1)) begin
                                n_pend = jbat_pkg::STAT_ENDED;
                            end else if (r_count == '0) begin
                                n_pend = jbat_pkg::STAT_COMMIT_EMPTY;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            jbat_pkg::S_SCAN_CMP: begin
                if (w_blk_hit) begin
                    n_pend = jbat_pkg::STAT_ABSORBED;
                end else if (w_idx_last) begin
                    w_mem_we = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    n_pend   = jbat_pkg::STAT_APPENDED;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            jbat_pkg::S_COMMIT_OUT: begin
                if (w_out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.status          = jbat_pkg::STAT_COMMIT_ENTRY;
                    n_out_item.home_block      = r_rd_data;
                    n_out_item.log_slot_block  = w_slot;
                    n_out_item.last            = w_idx_last;
                    if (w_idx_last) begin
                        n_count = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            jbat_pkg::S_PUT: begin
                if (w_out_free) begin
                    n_out_valid               = 1'b1;
                    n_out_item.status         = r_pend;
                    n_out_item.home_block     = (r_pend inside {jbat_pkg::STAT_ABSORBED,
                                                 jbat_pkg::STAT_APPENDED,
                                                 jbat_pkg::STAT_TOO_BIG,
                                                 jbat_pkg::STAT_OUTSIDE}) ? r_blk : '0;
                    n_out_item.log_slot_block = '0;
                    n_out_item.last           = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jbat_pkg::S_IDLE;
            r_open      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_start     <= '0;
            r_log_area_size <= jbat_pkg::AREA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jbat_pkg::CFG_LOG_START:     r_log_start <= i_cfg_data;
                jbat_pkg::CFG_LOG_AREA_SIZE: r_log_area_size <= i_cfg_data[jbat_pkg::AREA_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_blk      <= n_blk;
        r_pend     <= n_pend;
        r_out_item <= n_out_item;
    end

    // Block list: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_addr] <= r_blk;
        r_rd_data <= r_mem[r_idx];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jbat_checker.sv -----
// Port-level checker of the journal block absorb tracker, bound to the top level.
`default_nettype none
module jbat_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire jbat_pkg::t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // One item at a time: ready drops after an accepted item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after accepting an item");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= jbat_pkg::STAT_UNMATCHED)
        else $error("status code out of range");

    // Only commit entries may continue an item, and only they carry a slot
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != jbat_pkg::STAT_COMMIT_ENTRY
            |-> o_out_item.last && o_out_item.log_slot_block == '0)
        else $error("non-commit result not final or with slot");

endmodule

bind journal_block_absorb_tracker jbat_checker u_jbat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

// ----- dv/journal_check_pkg.sv -----
`timescale 1ns / 100ps
// Result predictor and in-order result checker for the journal block absorb tracker.
package journal_check_pkg;
    import jbat_pkg::*;

    class journal_checker;
        logic [BLK_W-1:0]  log_start;
        logic [AREA_W-1:0] area_size;
        logic [BLK_W-1:0]  listed_blocks [LOG_ENTRIES_DEF];
        int unsigned       entry_count;
        int unsigned       open_ops;
        t_out_item         pending_results [$];
        int unsigned       mismatches;

        function new();
            log_start   = '0;
            area_size   = AREA_RESET;
            entry_count = 0;
            open_ops    = 0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LOG_START) begin
                log_start = data[BLK_W-1:0];
            end else if (idx == CFG_LOG_AREA_SIZE) begin
                area_size = data[AREA_W-1:0];
            end
        endfunction

        function void queue_result(logic [3:0] status, logic [BLK_W-1:0] home,
                                   logic [BLK_W-1:0] slot, logic last);
            t_out_item r;
            r.status         = status;
            r.home_block     = home;
            r.log_slot_block = slot;
            r.last           = last;
            pending_results.push_back(r);
        endfunction

        // Advance the transaction state by one accepted item and queue its results.
        function void take_item(t_in_item it);
            int unsigned n;
            logic        hit;
            hit = 1'b0;
            case (it.opcode)
                OP_BEGIN: begin
                    if (entry_count + (open_ops + 1) * MAX_OP_BLOCKS_DEF > LOG_ENTRIES_DEF ||
                        open_ops >= OPEN_LIMIT) begin
                        queue_result(STAT_WAIT, '0, '0, 1'b1);
                    end else begin
                        open_ops++;
                        queue_result(STAT_GRANTED, '0, '0, 1'b1);
                    end
                end
                OP_WRITE: begin
                    if (entry_count >= LOG_ENTRIES_DEF || entry_count + 1 >= area_size) begin
                        queue_result(STAT_TOO_BIG, it.block_number, '0, 1'b1);
                    end else if (open_ops == 0) begin
                        queue_result(STAT_OUTSIDE, it.block_number, '0, 1'b1);
                    end else begin
                        for (n = 0; n < entry_count; n++) begin
                            if (listed_blocks[n] == it.block_number) hit = 1'b1;
                        end
                        if (hit) begin
                            queue_result(STAT_ABSORBED, it.block_number, '0, 1'b1);
                        end else begin
                            listed_blocks[entry_count] = it.block_number;
                            entry_count++;
                            queue_result(STAT_APPENDED, it.block_number, '0, 1'b1);
                        end
                    end
                end
                OP_END: begin
                    if (open_ops == 0) begin
                        queue_result(STAT_UNMATCHED, '0, '0, 1'b1);
                    end else begin
                        open_ops--;
                        if (open_ops != 0) begin
                            queue_result(STAT_ENDED, '0, '0, 1'b1);
                        end else if (entry_count == 0) begin
                            queue_result(STAT_COMMIT_EMPTY, '0, '0, 1'b1);
                        end else begin
                            for (n = 0; n < entry_count; n++) begin
                                queue_result(STAT_COMMIT_ENTRY, listed_blocks[n],
                                             log_start + n + 1, n + 1 == entry_count);
                            end
                            entry_count = 0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: status %0d home %h slot %h last %b",
                             got.status, got.home_block, got.log_slot_block, got.last);
                end
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.home_block !== want.home_block ||
                    got.log_slot_block !== want.log_slot_block || got.last !== want.last) begin
                    if (mismatches < 10) begin
                        $display("result mismatch: expected status %0d home %h slot %h last %b",
                                 want.status, want.home_block, want.log_slot_block, want.last);
                        $display("                 actual   status %0d home %h slot %h last %b",
                                 got.status, got.home_block, got.log_slot_block, got.last);
                    end
                    mismatches++;
                end
            end
        endfunction
    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the journal block absorb tracker: directed and random traffic.
module tb_top;
    import jbat_pkg::*;
    import journal_check_pkg::*;

    // Opcode that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles to let an ignored item or a commit finish before touching registers
    localparam int SETTLE_CYCLES = 12;
    // Extra idle time before the final check
    localparam int DRAIN_CYCLES  = 100;
    // Cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT    = 3000;
    // Receiver hold-off that fills the block and stalls its input
    localparam int HOLD_CYCLES   = 300;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    journal_checker journal = new();

    int unsigned tx_idle_pct = 11;
    int unsigned rx_idle_pct = 47;
    logic        hold_req    = 1'b0;
    logic        hold_taken  = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned quiet_cycles = 0;
    logic [BLK_W-1:0] recent_blocks [8];

    journal_block_absorb_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Result side: check every accepted result, then pick ready for the next edge.
    // A requested hold-off drops ready for a long stretch, counted here.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            journal.compare_result(o_out_item);
        end
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
            i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one item after a random gap; hold valid and payload until accepted.
    // Valid stays high on return so a back-to-back item needs no second assignment.
    task automatic offer_item(input logic [1:0] op, input logic [BLK_W-1:0] blk);
        t_in_item    it;
        int unsigned gap;
        it.opcode       = op;
        it.block_number = blk;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        journal.take_item(it);
    endtask

    // Drop valid and wait until every queued result is out and the block is idle.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (journal.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers while idle; junk above the area field must be masked.
    task automatic configure(input logic [BLK_W-1:0] start, input logic [AREA_W-1:0] area);
        logic [CFG_DATA_W-1:0] area_word;
        area_word = ($urandom() & ~((CFG_DATA_W'(1) << AREA_W) - 1)) | area;
        settle_block();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LOG_START;
        i_cfg_data <= start;
        @(posedge i_clk);
        journal.set_register(CFG_LOG_START, start);
        i_cfg_idx  <= CFG_LOG_AREA_SIZE;
        i_cfg_data <= area_word;
        @(posedge i_clk);
        journal.set_register(CFG_LOG_AREA_SIZE, area_word);
        i_cfg_we   <= 1'b0;
    endtask

    // Mix extremes, recently used blocks (to hit absorption) and fresh values.
    function automatic logic [BLK_W-1:0] pick_block();
        logic [BLK_W-1:0] v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2, 3, 4, 5: v = recent_blocks[$urandom_range(7)];
            default: begin
                v = $urandom();
                recent_blocks[$urandom_range(7)] = v;
            end
        endcase
        return v;
    endfunction

    // Mostly well-formed transactions (begin, writes, optional nested op, ends
    // down to a commit); the rest is loose items of any opcode.
    task automatic random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned n;
        logic [1:0]  op;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 75) begin
                offer_item(OP_BEGIN, pick_block());
                sent++;
                n = $urandom_range(6);
                repeat (n) begin
                    offer_item(OP_WRITE, pick_block());
                    sent++;
                end
                if ($urandom_range(1) == 1) begin
                    offer_item(OP_BEGIN, pick_block());
                    n = $urandom_range(4);
                    repeat (n) offer_item(OP_WRITE, pick_block());
                    offer_item(OP_END, pick_block());
                    sent += n + 2;
                end
                while (journal.open_ops != 0) begin
                    offer_item(OP_END, pick_block());
                    sent++;
                end
            end else begin
                op = 2'($urandom_range(3));
                offer_item(op, pick_block());
                if (op != OP_UNUSED) sent++;
            end
        end
    endtask

    initial begin
        for (int k = 0; k < 8; k++) recent_blocks[k] = $urandom();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: slots near the top of the address space, roomy log area
        configure(32'hFFFF_FFF0, 12'hFFF);
        offer_item(OP_UNUSED, $urandom());   // ignored, no result
        offer_item(OP_END, '0);              // end with nothing open
        offer_item(OP_WRITE, '1);            // write outside a transaction
        offer_item(OP_BEGIN, '0);
        offer_item(OP_WRITE, '0);
        offer_item(OP_WRITE, '1);
        offer_item(OP_WRITE, '0);            // absorbed
        offer_item(OP_WRITE, '1);            // absorbed
        offer_item(OP_BEGIN, '0);
        offer_item(OP_BEGIN, '0);            // fills the worst-case budget exactly
        offer_item(OP_BEGIN, '0);            // no room: wait
        offer_item(OP_END, '0);
        offer_item(OP_END, '0);
        offer_item(OP_END, '0);              // commit of two entries
        offer_item(OP_BEGIN, '0);
        offer_item(OP_END, '0);              // commit of an empty list

        // Directed: tiny log areas reject every write, then allow just one
        configure('0, 12'd0);
        offer_item(OP_BEGIN, '0);
        offer_item(OP_WRITE, $urandom());
        configure('0, 12'd1);
        offer_item(OP_WRITE, $urandom());
        configure('0, 12'd2);
        offer_item(OP_WRITE, $urandom());
        offer_item(OP_WRITE, $urandom());
        offer_item(OP_END, '0);

        // Random, default area size
        configure($urandom(), AREA_RESET);
        random_traffic(15);

        // Random, small areas, sender idles more than receiver
        tx_idle_pct = 47;
        rx_idle_pct <= 11;
        configure('1, AREA_W'($urandom_range(4, 40)));
        random_traffic(12);

        // No idling; slot addresses wrap through zero during the full commit
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        configure(32'hFFFF_FFF8, 12'hFFF);
        while (journal.open_ops != 0) offer_item(OP_END, '0);
        offer_item(OP_BEGIN, '0);
        repeat (34) offer_item(OP_WRITE, $urandom());   // list fills, then too big
        offer_item(OP_BEGIN, '0);                        // full list: wait
        while (journal.open_ops != 0) offer_item(OP_END, '0);

        // Hold the receiver off while items keep coming
        hold_req <= 1'b1;
        random_traffic(12);

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (journal.mismatches == 0 && journal.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
